[design/nntb_pkg.sv]
`default_nettype none

package nntb_pkg;

    // Widths of the fixed fields on the ports.
    localparam int CITY_BITS      = 6;
    localparam int EDGE_BITS      = 16;
    localparam int COUNT_BITS     = 7;
    localparam int TOUR_COST_BITS = 22;
    localparam int RUN_COST_BITS  = 23;

    // Largest tour that the position and city fields can describe.
    localparam int RESULT_CAP = 64;

    // Reset value of the city count register.
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd64;

    // Saturation limits of the cost accumulators.
    localparam logic [RUN_COST_BITS-1:0]  RUN_COST_MAX  = '1;
    localparam logic [TOUR_COST_BITS-1:0] TOUR_COST_MAX = '1;

    // Command codes of an input word.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_RUN   = 1'b1
    } t_op;

endpackage

`default_nettype wire

[design/nearest_neighbor_tour_builder_top.sv]
// Nearest-neighbor tour builder.
// Input channel (i_in_valid / o_in_ready): each word is either a cost write
// (i_op = write) that stores i_edge_cost at row i_from_city, column i_to_city,
// or a run command (i_op = run) that builds a greedy tour from city 0.
// Output channel (o_out_valid / i_out_ready): one word per tour city, in tour
// order, with its position; the final word has o_last set and carries the
// closed tour cost, saturated to 22 bits.
// i_cfg_we writes i_city_count, the number of cities used by a run.
// Throughput: cost writes are taken one per cycle while no run is in progress.
// A run holds the input until its last word is loaded; each step sweeps one
// row of the cost memory through its single read port, one entry per cycle,
// then passes through the compare drain, the update and the result.
// The first word is loaded from the emit state once the result register is free.
// If the receiver stalls, the result register holds its word and the scan
// waits at the next result; nothing is dropped. New writes are accepted while
// the last word of a run still waits.
// Reset clears the control state and sets the city count to 64; the cost
// memory is not cleared and must be written before it is used.
`default_nettype none

module nearest_neighbor_tour_builder_top #(
    parameter int MAX_CITIES = 64,
    parameter int COST_BITS  = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration.
    input  wire logic                                i_cfg_we,
    input  wire logic [nntb_pkg::COUNT_BITS-1:0]     i_city_count,
    // Input channel.
    input  wire logic                                i_in_valid,
    output      logic                                o_in_ready,
    input  wire logic                                i_op,
    input  wire logic [nntb_pkg::CITY_BITS-1:0]      i_from_city,
    input  wire logic [nntb_pkg::CITY_BITS-1:0]      i_to_city,
    input  wire logic [nntb_pkg::EDGE_BITS-1:0]      i_edge_cost,
    // Output channel.
    output      logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    output      logic [nntb_pkg::CITY_BITS-1:0]      o_city,
    output      logic [nntb_pkg::CITY_BITS-1:0]      o_position,
    output      logic [nntb_pkg::TOUR_COST_BITS-1:0] o_tour_cost,
    output      logic                                o_last
);

    localparam int CAP     = (MAX_CITIES < nntb_pkg::RESULT_CAP) ? MAX_CITIES
                                                                 : nntb_pkg::RESULT_CAP;
    localparam int CB      = $clog2(CAP);
    localparam int NB      = $clog2(CAP + 1);
    localparam int IB      = $clog2(MAX_CITIES);
    localparam int DEPTH   = 1 << (2 * IB);
    localparam int RC      = nntb_pkg::RUN_COST_BITS;
    localparam int SUM_W   = ((COST_BITS > RC) ? COST_BITS : RC) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_STEP,
        S_RET,
        S_RETW,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [nntb_pkg::COUNT_BITS-1:0] r_city_count;
    logic [NB-1:0]          r_n;
    logic [CAP-1:0]         r_visited;
    logic [CB-1:0]          r_cur;
    logic [CB-1:0]          r_pos;
    logic [CB-1:0]          r_j;
    logic [CB-1:0]          r_cmp_j;
    logic                   r_cmp_valid;
    logic                   r_found;
    logic [CB-1:0]          r_best;
    logic [COST_BITS-1:0]   r_best_cost;
    logic [RC-1:0]          r_run_cost;
    logic                   r_final;

    logic                   r_out_valid;
    logic [nntb_pkg::CITY_BITS-1:0]      r_out_city;
    logic [nntb_pkg::CITY_BITS-1:0]      r_out_pos;
    logic [nntb_pkg::TOUR_COST_BITS-1:0] r_out_cost;
    logic                   r_out_last;

    // Cost memory with one write and one registered read port.
    logic [COST_BITS-1:0]   mem [0:DEPTH-1];
    logic [COST_BITS-1:0]   r_rd_data;
    logic [2*IB-1:0]        n_raddr;
    logic [2*IB-1:0]        n_waddr;
    logic                   n_we;

    logic                   n_in_acc;
    logic                   n_out_free;
    logic [NB-1:0]          n_count;
    logic [COST_BITS-1:0]   n_add_in;
    logic [SUM_W-1:0]       n_sum;
    logic [RC-1:0]          n_sum_sat;
    logic [nntb_pkg::TOUR_COST_BITS-1:0] n_tour_sat;
    logic                   n_cand;

    assign o_in_ready  = (r_state == S_IDLE);
    assign n_in_acc    = i_in_valid && o_in_ready;
    assign n_out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_city      = r_out_city;
    assign o_position  = r_out_pos;
    assign o_tour_cost = r_out_cost;
    assign o_last      = r_out_last;

    // Memory addressing: row in the upper half, column in the lower half.
    assign n_we = n_in_acc && (i_op == nntb_pkg::OP_WRITE)
                  && (32'(i_from_city) < MAX_CITIES) && (32'(i_to_city) < MAX_CITIES);
    assign n_waddr = {IB'(i_from_city), IB'(i_to_city)};
    assign n_raddr = (r_state == S_RET) ? {IB'(r_cur), IB'(0)} : {IB'(r_cur), IB'(r_j)};

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[n_waddr] <= COST_BITS'(i_edge_cost);
        end
        r_rd_data <= mem[n_raddr];
    end

    // City count clamped to the supported range.
    always_comb begin
        if (r_city_count < 7'd2) begin
            n_count = NB'(2);
        end else if (32'(r_city_count) > CAP) begin
            n_count = NB'(CAP);
        end else begin
            n_count = NB'(r_city_count);
        end
    end

    // Saturating accumulator shared by the step cost and the return edge.
    assign n_add_in  = (r_state == S_RETW) ? r_rd_data : r_best_cost;
    assign n_sum     = SUM_W'(r_run_cost) + SUM_W'(n_add_in);
    assign n_sum_sat = (n_sum > SUM_W'(nntb_pkg::RUN_COST_MAX)) ? nntb_pkg::RUN_COST_MAX
                                                                 : RC'(n_sum);
    assign n_tour_sat = (r_run_cost > RC'(nntb_pkg::TOUR_COST_MAX))
                        ? nntb_pkg::TOUR_COST_MAX
                        : nntb_pkg::TOUR_COST_BITS'(r_run_cost);

    // A candidate is an unvisited column that is the first found or whose cost beats the best so far.
    assign n_cand = r_cmp_valid && !r_visited[r_cmp_j]
                    && (!r_found || (r_rd_data < r_best_cost));

    // Sequencer, scan compare and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_city_count <= nntb_pkg::COUNT_RESET;
            r_out_valid  <= 1'b0;
            r_cmp_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_visited    <= '0;
            r_cur        <= '0;
            r_run_cost   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_city_count <= i_city_count;
            end

            // A taken word frees the result register unless a new word loads it.
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            r_cmp_valid <= (r_state == S_SCAN);
            r_cmp_j     <= r_j;

            if (n_cand) begin
                r_found     <= 1'b1;
                r_best      <= r_cmp_j;
                r_best_cost <= r_rd_data;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc && (i_op == nntb_pkg::OP_RUN)) begin
                        r_n        <= n_count;
                        r_visited  <= CAP'(1);
                        r_cur      <= '0;
                        r_pos      <= '0;
                        r_run_cost <= '0;
                        r_final    <= 1'b0;
                        r_state    <= S_EMIT;
                    end
                end
                S_SCAN: begin
                    // Issue one column read per cycle across the current row.
                    r_j <= r_j + 1'b1;
                    if (NB'(r_j) == r_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_run_cost <= n_sum_sat;
                    r_cur      <= r_best;
                    r_visited  <= r_visited | (CAP'(1) << r_best);
                    if (NB'(r_pos) == r_n - 1'b1) begin
                        r_final <= 1'b1;
                        r_state <= S_RET;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_RET: begin
                    r_state <= S_RETW;
                end
                S_RETW: begin
                    r_run_cost <= n_sum_sat;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_city  <= nntb_pkg::CITY_BITS'(r_cur);
                        r_out_pos   <= nntb_pkg::CITY_BITS'(r_pos);
                        r_out_last  <= r_final;
                        r_out_cost  <= r_final ? n_tour_sat : '0;
                        if (r_final) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + 1'b1;
                            r_j     <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
